### design/yuvrgb_pkg.sv
`default_nettype none

package yuvrgb_pkg;

  localparam int unsigned CH_W   = 8;   // one color sample
  localparam int unsigned PROD_W = 15;  // |c| * coefficient, up to 22656
  localparam int unsigned RCP_W  = 13;
  localparam int unsigned SUM_W  = 10;  // signed channel before clamping
  localparam int unsigned CNT_W  = 2;

  localparam logic [CH_W-1:0] K_RV = 8'd140;
  localparam logic [CH_W-1:0] K_GU = 8'd34;
  localparam logic [CH_W-1:0] K_GV = 8'd71;
  localparam logic [CH_W-1:0] K_BU = 8'd177;
  localparam logic [CH_W-1:0] CHROMA_OFS = 8'd128;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  // floor(m / 100) == (m * 5243) >> 19 for every m below 2^15
  localparam logic [RCP_W-1:0] RCP_100 = 13'd5243;
  localparam int unsigned RCP_SH = 19;

  localparam logic [CNT_W-1:0] CNT_RGB24   = 2'd3;
  localparam logic [CNT_W-1:0] CNT_RGB1555 = 2'd2;

  typedef enum logic {
    FMT_RGB24   = 1'b0,
    FMT_RGB1555 = 1'b1
  } fmt_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  function automatic logic [CH_W-1:0] div100(input logic [PROD_W-1:0] m);
    logic [PROD_W+RCP_W-1:0] p;
    p = (PROD_W+RCP_W)'(m) * (PROD_W+RCP_W)'(RCP_100);
    return p[RCP_SH +: CH_W];
  endfunction

  function automatic logic signed [SUM_W-1:0] apply_sign(input logic neg,
                                                         input logic [CH_W-1:0] q);
    logic signed [SUM_W-1:0] s;
    s = $signed({{(SUM_W-CH_W){1'b0}}, q});
    return neg ? -s : s;
  endfunction

  function automatic logic [CH_W-1:0] sat8(input logic signed [SUM_W-1:0] x);
    logic [CH_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed({{(SUM_W-CH_W){1'b0}}, CH_MAX})) begin
      res = CH_MAX;
    end else begin
      res = x[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/yuvrgb_if.sv
`default_nettype none

interface yuvrgb_in_if;
  logic                        valid;
  logic                        ready;
  logic [yuvrgb_pkg::CH_W-1:0] luma;
  logic [yuvrgb_pkg::CH_W-1:0] chroma_blue;
  logic [yuvrgb_pkg::CH_W-1:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

interface yuvrgb_out_if;
  logic                         valid;
  logic                         ready;
  logic [yuvrgb_pkg::CH_W-1:0]  byte_first;
  logic [yuvrgb_pkg::CH_W-1:0]  byte_second;
  logic [yuvrgb_pkg::CH_W-1:0]  byte_third;
  logic [yuvrgb_pkg::CNT_W-1:0] byte_count;

  modport source (output valid, output byte_first, output byte_second,
                  output byte_third, output byte_count, input ready);
  modport sink   (input valid, input byte_first, input byte_second,
                  input byte_third, input byte_count, output ready);
endinterface

`default_nettype wire

### design/yuvrgb_pipe.sv
`default_nettype none

// Three-stage color matrix: constant products, divide by 100, sum and clamp.
module yuvrgb_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  yuvrgb_in_if.sink              in_ch,
  output      logic              pix_valid,
  input  wire logic              pix_ready,
  output      yuvrgb_pkg::rgb_t  pix
);

  localparam int unsigned CW = yuvrgb_pkg::CH_W;
  localparam int unsigned PW = yuvrgb_pkg::PROD_W;
  localparam int unsigned SW = yuvrgb_pkg::SUM_W;

  logic en1, en2, en3;
  logic v1_r, v2_r, v3_r;

  // stage 1: offset removal as sign/magnitude, constant products
  logic          u_neg, v_neg;
  logic [CW-1:0] u_mag, v_mag;
  logic [CW-1:0] y1_r;
  logic          un1_r, vn1_r;
  logic [PW-1:0] prv_r, pgu_r, pgv_r, pbu_r;

  // stage 2: quotients
  logic [CW-1:0] y2_r;
  logic          un2_r, vn2_r;
  logic [CW-1:0] qrv_r, qgu_r, qgv_r, qbu_r;

  // stage 3: signed sums, clamped
  logic signed [SW-1:0] y_s, r_sum, g_sum, b_sum;
  yuvrgb_pkg::rgb_t     rgb3_r;

  assign en3 = !v3_r || pix_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_comb begin
    u_neg = !in_ch.chroma_blue[CW-1];
    v_neg = !in_ch.chroma_red[CW-1];
    u_mag = u_neg ? yuvrgb_pkg::CHROMA_OFS - in_ch.chroma_blue
                  : in_ch.chroma_blue - yuvrgb_pkg::CHROMA_OFS;
    v_mag = v_neg ? yuvrgb_pkg::CHROMA_OFS - in_ch.chroma_red
                  : in_ch.chroma_red - yuvrgb_pkg::CHROMA_OFS;
  end

  always_comb begin
    y_s   = $signed({{(SW-CW){1'b0}}, y2_r});
    r_sum = y_s + yuvrgb_pkg::apply_sign(vn2_r, qrv_r);
    g_sum = y_s - yuvrgb_pkg::apply_sign(un2_r, qgu_r)
                - yuvrgb_pkg::apply_sign(vn2_r, qgv_r);
    b_sum = y_s + yuvrgb_pkg::apply_sign(un2_r, qbu_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      y1_r  <= in_ch.luma;
      un1_r <= u_neg;
      vn1_r <= v_neg;
      prv_r <= PW'(v_mag) * PW'(yuvrgb_pkg::K_RV);
      pgu_r <= PW'(u_mag) * PW'(yuvrgb_pkg::K_GU);
      pgv_r <= PW'(v_mag) * PW'(yuvrgb_pkg::K_GV);
      pbu_r <= PW'(u_mag) * PW'(yuvrgb_pkg::K_BU);
    end
    if (en2) begin
      y2_r  <= y1_r;
      un2_r <= un1_r;
      vn2_r <= vn1_r;
      qrv_r <= yuvrgb_pkg::div100(prv_r);
      qgu_r <= yuvrgb_pkg::div100(pgu_r);
      qgv_r <= yuvrgb_pkg::div100(pgv_r);
      qbu_r <= yuvrgb_pkg::div100(pbu_r);
    end
    if (en3) begin
      rgb3_r.r <= yuvrgb_pkg::sat8(r_sum);
      rgb3_r.g <= yuvrgb_pkg::sat8(g_sum);
      rgb3_r.b <= yuvrgb_pkg::sat8(b_sum);
    end
  end

  assign pix_valid = v3_r;
  assign pix       = rgb3_r;

endmodule

`default_nettype wire

### design/yuv_pixel_to_rgb_converter.sv
// Channel   Role    Handshake        Payload
// in_ch     sink    valid/ready      luma, chroma_blue, chroma_red (8b each)
// out_ch    source  valid/ready      byte_first..byte_third (8b), byte_count (2b)
// cfg       write   cfg_we           cfg_data: output format (0 BGR24, 1 RGB1555)
//
// Four register stages: products, divide by 100, sum/clamp, pack.
// One item per cycle while out_ch.ready is high; each stage holds only while its successor is full
// and stalled, so bubbles collapse and nothing is dropped or repeated.
// rst_n is synchronous: clears all valid bits and sets the format to BGR24.
`default_nettype none

module yuv_pixel_to_rgb_converter (
  input  wire logic clk,
  input  wire logic rst_n,
  yuvrgb_in_if.sink   in_ch,
  yuvrgb_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_data
);

  localparam int unsigned CW = yuvrgb_pkg::CH_W;

  yuvrgb_pkg::fmt_t fmt_r;
  logic             pix_valid, pix_ready;
  yuvrgb_pkg::rgb_t pix;

  logic                         ov_r;
  logic [CW-1:0]                b0_r, b1_r, b2_r;
  logic [yuvrgb_pkg::CNT_W-1:0] cnt_r;
  logic [15:0]                  word;

  yuvrgb_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  assign pix_ready = !ov_r || out_ch.ready;

  // RGB1555: top five bits of each channel, bit 15 clear
  assign word = {1'b0, pix.r[CW-1 -: 5], pix.g[CW-1 -: 5], pix.b[CW-1 -: 5]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= yuvrgb_pkg::FMT_RGB24;
      ov_r  <= 1'b0;
    end else begin
      if (cfg_we) fmt_r <= yuvrgb_pkg::fmt_t'(cfg_data);
      if (pix_ready) ov_r <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready) begin
      case (fmt_r)
        yuvrgb_pkg::FMT_RGB24: begin
          b0_r  <= pix.b;
          b1_r  <= pix.g;
          b2_r  <= pix.r;
          cnt_r <= yuvrgb_pkg::CNT_RGB24;
        end
        yuvrgb_pkg::FMT_RGB1555: begin
          b0_r  <= word[7:0];
          b1_r  <= word[15:8];
          b2_r  <= '0;
          cnt_r <= yuvrgb_pkg::CNT_RGB1555;
        end
        default: begin
          b0_r  <= pix.b;
          b1_r  <= pix.g;
          b2_r  <= pix.r;
          cnt_r <= yuvrgb_pkg::CNT_RGB24;
        end
      endcase
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.byte_first  = b0_r;
  assign out_ch.byte_second = b1_r;
  assign out_ch.byte_third  = b2_r;
  assign out_ch.byte_count  = cnt_r;

endmodule

`default_nettype wire

### design/yuvrgb_chk.sv
`default_nettype none

module yuvrgb_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [yuvrgb_pkg::CH_W-1:0]  out_byte_second,
  input wire logic [yuvrgb_pkg::CH_W-1:0]  out_byte_third,
  input wire logic [yuvrgb_pkg::CNT_W-1:0] out_byte_count
);

  // a pending item is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out item dropped while stalled");

  a_no_valid_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("out valid right after reset");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == yuvrgb_pkg::CNT_RGB24 ||
                   out_byte_count == yuvrgb_pkg::CNT_RGB1555))
    else $error("bad byte count");

  // 16-bit word: third byte empty, top bit clear
  a_1555_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == yuvrgb_pkg::CNT_RGB1555 |->
      out_byte_third == '0 && !out_byte_second[yuvrgb_pkg::CH_W-1])
    else $error("malformed RGB1555 item");

endmodule

bind yuv_pixel_to_rgb_converter yuvrgb_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_byte_second (out_ch.byte_second),
  .out_byte_third  (out_ch.byte_third),
  .out_byte_count  (out_ch.byte_count)
);

`default_nettype wire
